/* rtl/round_robin_thread_scheduler_core_macros.svh */
// assertion macros for the round robin thread scheduler
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rrts_pkg.sv */
// package: types, constants and codes for the round robin thread scheduler
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int WALK_LIMIT = 2 * SLOTS + 2;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 1);

  localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(SLOTS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WALK_LIMIT);

  localparam logic [2:0] MODE_YIELD  = 3'd0;
  localparam logic [2:0] MODE_CREATE = 3'd1;
  localparam logic [2:0] MODE_SLEEP  = 3'd2;
  localparam logic [2:0] MODE_JOIN   = 3'd3;
  localparam logic [2:0] MODE_DETACH = 3'd4;
  localparam logic [2:0] MODE_EXIT   = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  localparam logic [9:0]  NS_PER_US = 10'd1000;
  // ceil(2^46 / 125): quotient of a 39-bit value by 125 is (x * DIV_RECIP) >> 46
  localparam logic [39:0] DIV_RECIP = 40'd562949953422;
  localparam logic [63:0] DIV_SAT   = 64'd1000 << 32;
  localparam logic [1:0]  DIV_LAST  = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [62:0] now_ns;
    logic [31:0] sleep_us;
    logic [3:0]  target_slot;
  } in_t;

  typedef struct packed {
    logic [3:0]  running_slot;
    logic        switched;
    logic [31:0] idle_us;
    logic [3:0]  new_slot;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_WINIT, S_WALK, S_WEND, S_DIV, S_FIX, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CAPTURE, CMD_UPDATE, CMD_NOWALK, CMD_WINIT,
    CMD_WSTEP, CMD_WEND, CMD_DSTEP, CMD_FIX
  } cmd_t;

  typedef struct packed {
    logic do_walk;
    logic q_empty;
    logic walk_stop;
    logic is_idle;
    logic div_done;
  } dp_status_t;

endpackage

/* rtl/rrts_ctrl.sv */
// controller state machine sequencing update, walk, divide and result
`timescale 1ns / 1ps
module rrts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rrts_pkg::dp_status_t st,
  output rrts_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                out_valid
);

  rrts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = rrts_pkg::CMD_NONE;
    unique case (state_r)
      rrts_pkg::S_IDLE: begin
        if (start) begin
          cmd       = rrts_pkg::CMD_CAPTURE;
          state_nxt = rrts_pkg::S_UPD;
        end
      end
      rrts_pkg::S_UPD: begin
        cmd       = rrts_pkg::CMD_UPDATE;
        state_nxt = rrts_pkg::S_WINIT;
      end
      rrts_pkg::S_WINIT: begin
        if (!st.do_walk || st.q_empty) begin
          cmd       = rrts_pkg::CMD_NOWALK;
          state_nxt = rrts_pkg::S_OUT;
        end else begin
          cmd       = rrts_pkg::CMD_WINIT;
          state_nxt = rrts_pkg::S_WALK;
        end
      end
      rrts_pkg::S_WALK: begin
        if (st.walk_stop) begin
          state_nxt = rrts_pkg::S_WEND;
        end else begin
          cmd = rrts_pkg::CMD_WSTEP;
        end
      end
      rrts_pkg::S_WEND: begin
        cmd       = rrts_pkg::CMD_WEND;
        state_nxt = st.is_idle ? rrts_pkg::S_DIV : rrts_pkg::S_FIX;
      end
      rrts_pkg::S_DIV: begin
        cmd = rrts_pkg::CMD_DSTEP;
        if (st.div_done) begin
          state_nxt = rrts_pkg::S_FIX;
        end
      end
      rrts_pkg::S_FIX: begin
        cmd       = rrts_pkg::CMD_FIX;
        state_nxt = rrts_pkg::S_OUT;
      end
      rrts_pkg::S_OUT: begin
        state_nxt = rrts_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rrts_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != rrts_pkg::S_IDLE);
  assign out_valid = (state_r == rrts_pkg::S_OUT);

endmodule

/* rtl/rrts_dp.sv */
// datapath: slot table, queue links, walk registers and idle divider
`timescale 1ns / 1ps
module rrts_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrts_pkg::cmd_t       cmd,
  input  rrts_pkg::in_t        in_data,
  output rrts_pkg::dp_status_t st,
  output rrts_pkg::out_t       out_data
);

  localparam int SW = rrts_pkg::SLOT_W;
  localparam int LW = rrts_pkg::LINK_W;

  // slot table
  logic [rrts_pkg::SLOTS-1:0] used_r, inq_r, det_r, pend_r;
  logic [63:0]   wake_r [rrts_pkg::SLOTS];
  logic [SW-1:0] jt_r   [rrts_pkg::SLOTS];
  logic [LW-1:0] link_r [rrts_pkg::SLOTS];
  logic [LW-1:0] head_r, tail_r;
  logic [SW-1:0] cur_r;

  // event registers
  logic [2:0]    mode_r;
  logic [62:0]   now_r;
  logic [41:0]   slp_r;
  logic [SW-1:0] tgt_r;
  logic [SW-1:0] cur0_r;
  logic          walk_r;

  // walk and divider registers
  logic [SW-1:0]                base_r, before_r;
  logic [LW-1:0]                nxt_r;
  logic [63:0]                  minw_r;
  logic [rrts_pkg::STEP_W-1:0]  steps_r;
  logic                         brk_r, s1_r, idle_r;
  logic [63:0]                  rem_r;
  logic [78:0]                  acc_r;
  logic [1:0]                   dcnt_r;
  rrts_pkg::out_t               out_r;

  logic [SW-1:0] cur_w, rd_addr, nxt_f, free_idx, pred_idx, start_s;
  logic          free_found, pred_found, waited, is_idle;
  logic [63:0]   wake_rd;
  logic [LW-1:0] link_rd, lc, head_n, tail_n;
  logic [rrts_pkg::SLOTS-1:0] waited_vec, cur_hot;
  logic [31:0]   idle_val;
  logic          fix_sw;
  logic          upd_walk, join_ref, wend_sw;
  logic [1:0]    upd_status;
  logic [SW-1:0] upd_new, wend_cur;
  logic [12:0]   chunk;
  logic [52:0]   prod;

  assign cur_w   = inq_r[cur_r] ? cur_r : head_r[SW-1:0];
  assign rd_addr = (cmd == rrts_pkg::CMD_WINIT) ? cur_w : nxt_r[SW-1:0];
  assign wake_rd = wake_r[rd_addr];
  assign link_rd = link_r[rd_addr];
  assign nxt_f   = nxt_r[LW-1] ? base_r : nxt_r[SW-1:0];
  assign is_idle = ({1'b0, now_r} < minw_r);
  assign cur_hot = rrts_pkg::SLOTS'(1) << cur_r;
  assign join_ref = (tgt_r == cur_r) || !used_r[tgt_r] || det_r[tgt_r];
  assign wend_sw  = !is_idle && !pend_r[nxt_f];
  assign wend_cur = wend_sw ? nxt_f : base_r;
  assign prod     = 53'(chunk) * 53'(rrts_pkg::DIV_RECIP);

  // free slot and predecessor search
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    pred_found = 1'b0;
    pred_idx   = '0;
    for (int i = rrts_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
      if (inq_r[i] && link_r[i] == {1'b0, cur_r}) begin
        pred_found = 1'b1;
        pred_idx   = SW'(i);
      end
    end
  end

  // event status, walk request and created slot
  always_comb begin
    upd_walk   = 1'b1;
    upd_status = rrts_pkg::STATUS_OK;
    upd_new    = '0;
    unique case (mode_r)
      rrts_pkg::MODE_CREATE: begin
        if (!free_found) begin
          upd_status = rrts_pkg::STATUS_NO_SLOT;
          upd_walk   = 1'b0;
        end else begin
          upd_new = free_idx;
        end
      end
      rrts_pkg::MODE_JOIN: begin
        upd_walk = 1'b0;
        if (join_ref) begin
          upd_status = rrts_pkg::STATUS_REFUSED;
        end else if (inq_r[tgt_r]) begin
          upd_walk = 1'b1;
        end
      end
      rrts_pkg::MODE_DETACH: begin
        upd_walk = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // exit unlink
  always_comb begin
    lc      = link_r[cur_r];
    start_s = lc[LW-1] ? head_r[SW-1:0] : lc[SW-1:0];
    head_n  = (head_r == {1'b0, cur_r}) ? lc : head_r;
    tail_n  = tail_r;
    if (tail_r == {1'b0, cur_r}) begin
      tail_n = pred_found ? {1'b0, pred_idx} : rrts_pkg::END_MARK;
    end
    if (head_n[LW-1]) begin
      head_n = rrts_pkg::END_MARK;
      tail_n = rrts_pkg::END_MARK;
    end
    for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
      waited_vec[i] = inq_r[i] && (SW'(i) != cur_r) && pend_r[i] && (jt_r[i] == cur_r);
    end
    waited = |waited_vec;
  end

  // divider operand, top chunk first
  always_comb begin
    unique case (dcnt_r)
      2'd0:    chunk = rem_r[41:29];
      2'd1:    chunk = rem_r[28:16];
      default: chunk = rem_r[15:3];
    endcase
  end

  // final result
  always_comb begin
    idle_val = '0;
    if (idle_r) begin
      idle_val = (rem_r >= rrts_pkg::DIV_SAT) ? 32'hFFFF_FFFF : acc_r[77:46];
    end
    fix_sw = s1_r || ((mode_r == rrts_pkg::MODE_EXIT) && (cur_r != cur0_r) &&
             (idle_val == '0) && !pend_r[cur_r] && inq_r[cur_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= rrts_pkg::SLOTS'(1);
      inq_r  <= rrts_pkg::SLOTS'(1);
      det_r  <= '0;
      pend_r <= '0;
      for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
        wake_r[i] <= '0;
        jt_r[i]   <= '0;
        link_r[i] <= rrts_pkg::END_MARK;
      end
      head_r <= '0;
      tail_r <= '0;
      cur_r  <= '0;
      walk_r <= 1'b0;
      brk_r  <= 1'b0;
      steps_r <= '0;
      dcnt_r <= '0;
      idle_r <= 1'b0;
      s1_r   <= 1'b0;
    end else begin
      unique case (cmd)
        rrts_pkg::CMD_CAPTURE: begin
          mode_r <= in_data.mode;
          now_r  <= in_data.now_ns;
          slp_r  <= 42'(in_data.sleep_us) * 42'(rrts_pkg::NS_PER_US);
          tgt_r  <= in_data.target_slot;
          cur0_r <= cur_r;
        end
        rrts_pkg::CMD_UPDATE: begin
          walk_r          <= upd_walk;
          out_r.status    <= upd_status;
          out_r.new_slot  <= upd_new;
          out_r.switched  <= 1'b0;
          out_r.idle_us   <= '0;
          idle_r          <= 1'b0;
          s1_r            <= 1'b0;
          unique case (mode_r)
            rrts_pkg::MODE_CREATE: begin
              if (free_found) begin
                used_r[free_idx] <= 1'b1;
                det_r[free_idx]  <= 1'b0;
                pend_r[free_idx] <= 1'b0;
                inq_r[free_idx]  <= 1'b1;
                wake_r[free_idx] <= '0;
                jt_r[free_idx]   <= '0;
                link_r[free_idx] <= rrts_pkg::END_MARK;
                if (head_r[LW-1]) begin
                  head_r <= {1'b0, free_idx};
                end else begin
                  link_r[tail_r[SW-1:0]] <= {1'b0, free_idx};
                end
                tail_r <= {1'b0, free_idx};
              end
            end
            rrts_pkg::MODE_SLEEP: begin
              wake_r[cur_r] <= {1'b0, now_r} + 64'(slp_r);
            end
            rrts_pkg::MODE_JOIN: begin
              if (join_ref) begin
              end else if (!inq_r[tgt_r]) begin
                used_r[tgt_r] <= 1'b0;
                det_r[tgt_r]  <= 1'b0;
                pend_r[tgt_r] <= 1'b0;
              end else begin
                pend_r[cur_r] <= 1'b1;
                jt_r[cur_r]   <= tgt_r;
              end
            end
            rrts_pkg::MODE_DETACH: begin
              det_r[cur_r] <= 1'b1;
            end
            rrts_pkg::MODE_EXIT: begin
              if (inq_r[cur_r]) begin
                if (pred_found) begin
                  link_r[pred_idx] <= lc;
                end
                link_r[cur_r] <= rrts_pkg::END_MARK;
                inq_r[cur_r]  <= 1'b0;
                pend_r        <= pend_r & ~(waited_vec | cur_hot);
                if (det_r[cur_r] || waited) begin
                  used_r[cur_r] <= 1'b0;
                  det_r[cur_r]  <= 1'b0;
                end
                head_r <= head_n;
                tail_r <= tail_n;
                if (!head_n[LW-1]) begin
                  cur_r <= start_s;
                end
              end
            end
            default: begin
            end
          endcase
        end
        rrts_pkg::CMD_NOWALK: begin
          out_r.running_slot <= cur_r;
        end
        rrts_pkg::CMD_WINIT: begin
          base_r   <= cur_w;
          before_r <= cur_r;
          minw_r   <= wake_rd;
          nxt_r    <= link_rd;
          steps_r  <= '0;
          brk_r    <= 1'b0;
        end
        rrts_pkg::CMD_WSTEP: begin
          steps_r <= steps_r + 1'b1;
          if (nxt_r[LW-1]) begin
            nxt_r <= head_r;
          end else if (pend_r[nxt_r[SW-1:0]]) begin
            nxt_r <= link_rd;
          end else begin
            if (wake_rd < minw_r) begin
              minw_r <= wake_rd;
            end
            if (wake_rd < {1'b0, now_r}) begin
              brk_r <= 1'b1;
            end else begin
              nxt_r <= link_rd;
            end
          end
        end
        rrts_pkg::CMD_WEND: begin
          cur_r  <= wend_cur;
          idle_r <= is_idle;
          if (wend_sw) begin
            s1_r <= (nxt_f != before_r);
          end
          rem_r  <= minw_r - {1'b0, now_r};
          acc_r  <= '0;
          dcnt_r <= '0;
        end
        rrts_pkg::CMD_DSTEP: begin
          acc_r  <= {acc_r[65:0], 13'd0} + 79'(prod);
          dcnt_r <= dcnt_r + 1'b1;
        end
        rrts_pkg::CMD_FIX: begin
          out_r.running_slot <= cur_r;
          out_r.idle_us      <= idle_val;
          out_r.switched     <= fix_sw ? (cur_r != cur0_r) : 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign st.do_walk   = walk_r;
  assign st.q_empty   = head_r[LW-1];
  assign st.walk_stop = brk_r || (nxt_r == {1'b0, base_r}) || (steps_r == rrts_pkg::STEP_LAST);
  assign st.is_idle   = is_idle;
  assign st.div_done  = (dcnt_r == rrts_pkg::DIV_LAST);
  assign out_data     = out_r;

endmodule

/* rtl/round_robin_thread_scheduler_core.sv */
// a transfer passes the update and walk-init states; an event that does not walk then
// shows its result; else the walk visits linked slots one at a time, at most 34 steps,
// then walk-end, the idle divide when idling (a reciprocal multiply), fix and result
// one event at a time: busy stays high until the result strobe has gone
// synchronous active-low reset: slot 0 is the main thread, queued and current
// results cannot be stalled and are shown for one cycle only
`timescale 1ns / 1ps
`include "round_robin_thread_scheduler_core_macros.svh"
module round_robin_thread_scheduler_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rrts_pkg::in_t  in_data,
  output logic           out_valid,
  output rrts_pkg::out_t out_data
);

  rrts_pkg::cmd_t       cmd;
  rrts_pkg::dp_status_t st;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rrts_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .st       (st),
    .out_data (out_data)
  );

  `RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
  `RRTS_ASSERT_NOW(a_strobe_busy, out_valid, busy, "result strobe while idle")
  `RRTS_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid && !busy, "result strobe repeated")
  `RRTS_ASSERT_NOW(a_status_code, out_valid, out_data.status <= rrts_pkg::STATUS_REFUSED, "bad status code")

endmodule
